>>> rtl/assert_macros.svh
// Assertion helpers for the watchdog checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define MCPW_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("watchdog check failed: same-cycle implication");

// Next-cycle implication, sampled on clk, off during reset.
`define MCPW_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("watchdog check failed: next-cycle implication");

`endif

>>> rtl/mcpw_pkg.sv
`default_nettype none

package mcpw_pkg;

  localparam int DEF_NUM_CHANNELS = 16;
  localparam int DEF_TIME_BITS    = 32;

  localparam int FUNC_W    = 3;
  localparam int CH_PORT_W = 4;
  localparam int LIM_W     = 32;
  localparam int CAUSE_W   = 2;

  localparam logic [FUNC_W-1:0] F_START    = 3'd0;
  localparam logic [FUNC_W-1:0] F_REGISTER = 3'd1;
  localparam logic [FUNC_W-1:0] F_PROGRESS = 3'd2;
  localparam logic [FUNC_W-1:0] F_COMPLETE = 3'd3;
  localparam logic [FUNC_W-1:0] F_TICK     = 3'd4;
  localparam logic [FUNC_W-1:0] F_CHECK    = 3'd5;
  localparam logic [FUNC_W-1:0] F_STOP     = 3'd6;

  localparam logic [CAUSE_W-1:0] CAUSE_NONE   = 2'd0;
  localparam logic [CAUSE_W-1:0] CAUSE_GLOBAL = 2'd1;
  localparam logic [CAUSE_W-1:0] CAUSE_CHAN   = 2'd2;

endpackage

`default_nettype wire

>>> rtl/mcpw_ram.sv
`default_nettype none

module mcpw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> rtl/mcpw_elapsed_cmp.sv
`default_nettype none

module mcpw_elapsed_cmp #(
  parameter int TIME_BITS = 32,
  parameter int LIM_BITS  = 32
) (
  input  wire logic [TIME_BITS-1:0] now,
  input  wire logic [TIME_BITS-1:0] base,
  input  wire logic [LIM_BITS-1:0]  limit,
  output logic                      overdue
);

  localparam int CMP_W = (TIME_BITS > LIM_BITS) ? TIME_BITS : LIM_BITS;

  logic [TIME_BITS-1:0] elapsed;

  always_comb begin
    elapsed = now - base;
    overdue = CMP_W'(elapsed) >= CMP_W'(limit);
  end

endmodule

`default_nettype wire

>>> rtl/multi_channel_progress_watchdog.sv
// Channel   Ports                                   Handshake
// input     start, busy, in_func/channel/timeout   taken when start && !busy
// result    out_valid, out_timed_out/cause/...     one-cycle strobe, no stall
// config    cfg_valid, cfg_ready, cfg_data         written when valid && ready
//
// Non-check items, and checks while stopped or tripped, keep busy low and give
// their result in the cycle after they are taken.
// A running check holds busy through one global deadline compare, then one
// slot per cycle through the shared elapsed compare, ending at a global trip
// or at the first overdue channel; its result shows as busy drops.
// Synchronous active-low reset clears all control state and channel marks.
// The result side cannot stall; cfg_ready is always high.
`default_nettype none

module multi_channel_progress_watchdog
  import mcpw_pkg::*;
#(
  parameter int NUM_CHANNELS = DEF_NUM_CHANNELS,
  parameter int TIME_BITS    = DEF_TIME_BITS
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [FUNC_W-1:0]    in_func,
  input  wire logic [CH_PORT_W-1:0] in_channel,
  input  wire logic [LIM_W-1:0]     in_channel_timeout,
  output logic                      out_valid,
  output logic                      out_timed_out,
  output logic [CAUSE_W-1:0]        out_cause,
  output logic [CH_PORT_W-1:0]      out_fault_channel,
  output logic                      out_active,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [LIM_W-1:0]     cfg_data
);

  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_GLOBAL = 2'd1;
  localparam logic [1:0] ST_WALK   = 2'd2;

  logic [1:0]              state_r, state_nxt;
  logic [CH_W-1:0]         idx_r, idx_nxt;
  logic [TIME_BITS-1:0]    now_r, now_nxt;
  logic [TIME_BITS-1:0]    start_r, start_nxt;
  logic                    running_r, running_nxt;
  logic                    expired_r, expired_nxt;
  logic [CAUSE_W-1:0]      cause_r, cause_nxt;
  logic [CH_PORT_W-1:0]    fch_r, fch_nxt;
  logic [NUM_CHANNELS-1:0] valid_r, valid_nxt;
  logic [NUM_CHANNELS-1:0] done_r, done_nxt;
  logic [LIM_W-1:0]        total_r;

  logic                    out_valid_r;
  logic                    out_timed_out_r;
  logic [CAUSE_W-1:0]      out_cause_r;
  logic [CH_PORT_W-1:0]    out_fault_channel_r;
  logic                    out_active_r;

  logic                    accept;
  logic                    fin;
  logic                    ch_ok;
  logic [CH_W-1:0]         ch_idx;
  logic                    lim_we;
  logic                    prog_we;
  logic [CH_W-1:0]         raddr;
  logic [LIM_W-1:0]        lim_rdata;
  logic [TIME_BITS-1:0]    prog_rdata;
  logic [TIME_BITS-1:0]    cmp_base;
  logic [LIM_W-1:0]        cmp_limit;
  logic                    overdue;

  assign accept    = start && (state_r == ST_IDLE);
  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign ch_ok     = 32'(in_channel) < 32'(NUM_CHANNELS);
  assign ch_idx    = CH_W'(in_channel);

  assign lim_we  = accept && (in_func == F_REGISTER) && ch_ok;
  assign prog_we = lim_we ||
                   (accept && (in_func == F_PROGRESS) && ch_ok &&
                    valid_r[ch_idx] && !done_r[ch_idx]);
  assign raddr   = (state_r == ST_WALK) ? CH_W'(idx_r + 1'b1) : '0;

  mcpw_ram #(
    .WIDTH (LIM_W),
    .DEPTH (NUM_CHANNELS)
  ) u_lim_ram (
    .clk   (clk),
    .we    (lim_we),
    .waddr (ch_idx),
    .wdata (in_channel_timeout),
    .raddr (raddr),
    .rdata (lim_rdata)
  );

  mcpw_ram #(
    .WIDTH (TIME_BITS),
    .DEPTH (NUM_CHANNELS)
  ) u_prog_ram (
    .clk   (clk),
    .we    (prog_we),
    .waddr (ch_idx),
    .wdata (now_r),
    .raddr (raddr),
    .rdata (prog_rdata)
  );

  assign cmp_base  = (state_r == ST_GLOBAL) ? start_r : prog_rdata;
  assign cmp_limit = (state_r == ST_GLOBAL) ? total_r : lim_rdata;

  mcpw_elapsed_cmp #(
    .TIME_BITS (TIME_BITS),
    .LIM_BITS  (LIM_W)
  ) u_cmp (
    .now     (now_r),
    .base    (cmp_base),
    .limit   (cmp_limit),
    .overdue (overdue)
  );

  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    now_nxt     = now_r;
    start_nxt   = start_r;
    running_nxt = running_r;
    expired_nxt = expired_r;
    cause_nxt   = cause_r;
    fch_nxt     = fch_r;
    valid_nxt   = valid_r;
    done_nxt    = done_r;
    fin         = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          fin = 1'b1;
          case (in_func)
            F_START: begin
              if (!running_r) begin
                start_nxt   = now_r;
                expired_nxt = 1'b0;
                cause_nxt   = CAUSE_NONE;
                fch_nxt     = '0;
                running_nxt = 1'b1;
              end
            end
            F_REGISTER: begin
              if (ch_ok) begin
                valid_nxt[ch_idx] = 1'b1;
                done_nxt[ch_idx]  = 1'b0;
              end
            end
            F_COMPLETE: begin
              if (ch_ok && valid_r[ch_idx]) begin
                done_nxt[ch_idx] = 1'b1;
              end
            end
            F_TICK: begin
              now_nxt = now_r + 1'b1;
            end
            F_CHECK: begin
              if (running_r && !expired_r) begin
                fin       = 1'b0;
                state_nxt = ST_GLOBAL;
              end
            end
            F_STOP: begin
              running_nxt = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_GLOBAL: begin
        if (overdue) begin
          expired_nxt = 1'b1;
          cause_nxt   = CAUSE_GLOBAL;
          fch_nxt     = '0;
          fin         = 1'b1;
          state_nxt   = ST_IDLE;
        end else begin
          idx_nxt   = '0;
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (valid_r[idx_r] && !done_r[idx_r] && overdue) begin
          expired_nxt = 1'b1;
          cause_nxt   = CAUSE_CHAN;
          fch_nxt     = CH_PORT_W'(idx_r);
          fin         = 1'b1;
          state_nxt   = ST_IDLE;
        end else if (idx_r == CH_W'(NUM_CHANNELS - 1)) begin
          fin       = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      now_r       <= '0;
      start_r     <= '0;
      running_r   <= 1'b0;
      expired_r   <= 1'b0;
      cause_r     <= CAUSE_NONE;
      fch_r       <= '0;
      valid_r     <= '0;
      done_r      <= '0;
      total_r     <= '1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      now_r       <= now_nxt;
      start_r     <= start_nxt;
      running_r   <= running_nxt;
      expired_r   <= expired_nxt;
      cause_r     <= cause_nxt;
      fch_r       <= fch_nxt;
      valid_r     <= valid_nxt;
      done_r      <= done_nxt;
      out_valid_r <= fin;
      if (cfg_valid && cfg_ready) begin
        total_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      out_timed_out_r     <= expired_nxt;
      out_cause_r         <= cause_nxt;
      out_fault_channel_r <= (cause_nxt == CAUSE_CHAN) ? fch_nxt : '0;
      out_active_r        <= running_nxt && !expired_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_timed_out     = out_timed_out_r;
  assign out_cause         = out_cause_r;
  assign out_fault_channel = out_fault_channel_r;
  assign out_active        = out_active_r;

endmodule

`default_nettype wire

>>> rtl/mcpw_checker.sv
`default_nettype none

`include "assert_macros.svh"

module mcpw_checker
  import mcpw_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 start,
  input wire logic                 busy,
  input wire logic [FUNC_W-1:0]    in_func,
  input wire logic                 out_valid,
  input wire logic                 out_timed_out,
  input wire logic [CAUSE_W-1:0]   out_cause,
  input wire logic [CH_PORT_W-1:0] out_fault_channel,
  input wire logic                 out_active
);

  `MCPW_ASSERT_NXT(a_quick_result, start && !busy && (in_func != F_CHECK), out_valid)
  `MCPW_ASSERT_IMP(a_flag_matches_cause, out_valid, out_timed_out == (out_cause != CAUSE_NONE))
  `MCPW_ASSERT_IMP(a_no_active_when_tripped, out_valid, !(out_active && out_timed_out))
  `MCPW_ASSERT_IMP(a_fault_only_on_chan, out_valid && (out_cause != CAUSE_CHAN), out_fault_channel == '0)

endmodule

bind multi_channel_progress_watchdog mcpw_checker u_mcpw_checker (.*);

`default_nettype wire

>>> tb/testbench.sv
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import mcpw_pkg::*;

  localparam int NCH = DEF_NUM_CHANNELS;
  localparam logic [FUNC_W-1:0] F_RESERVED = 3'd7;
  localparam int QUIET_LIMIT = 400;
  localparam int PHASE_ITEMS = 300;

  typedef struct packed {
    logic [FUNC_W-1:0]    func;
    logic [CH_PORT_W-1:0] ch;
    logic [LIM_W-1:0]     tmo;
  } wd_cmd_t;

  typedef struct packed {
    logic               timed_out;
    logic [CAUSE_W-1:0] cause;
    logic [CH_PORT_W-1:0] fault_ch;
    logic               active;
  } wd_status_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [FUNC_W-1:0] in_func = '0;
  logic [CH_PORT_W-1:0] in_channel = '0;
  logic [LIM_W-1:0] in_channel_timeout = '0;
  logic out_valid;
  logic out_timed_out;
  logic [CAUSE_W-1:0] out_cause;
  logic [CH_PORT_W-1:0] out_fault_channel;
  logic out_active;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [LIM_W-1:0] cfg_data = '0;

  multi_channel_progress_watchdog #(
    .NUM_CHANNELS(NCH),
    .TIME_BITS(DEF_TIME_BITS)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_func(in_func),
    .in_channel(in_channel),
    .in_channel_timeout(in_channel_timeout),
    .out_valid(out_valid),
    .out_timed_out(out_timed_out),
    .out_cause(out_cause),
    .out_fault_channel(out_fault_channel),
    .out_active(out_active),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // watchdog model state
  logic [31:0] deadline_ms = 32'hFFFF_FFFF;
  logic [31:0] now_ms = '0;
  logic [31:0] start_ms = '0;
  logic running = 1'b0;
  logic expired = 1'b0;
  logic [CAUSE_W-1:0] trip_cause = CAUSE_NONE;
  logic [CH_PORT_W-1:0] trip_ch = '0;
  logic slot_valid [NCH];
  logic slot_done [NCH];
  logic [31:0] slot_limit [NCH];
  logic [31:0] slot_last [NCH];

  wd_cmd_t pending_cmds[$];
  wd_status_t status_due[$];
  logic [31:0] deadline_req[$];
  wd_cmd_t cur_cmd;
  wd_status_t got_st;
  wd_status_t want_st;
  int items_pushed = 0;
  int items_taken = 0;
  int cfg_writes = 0;
  int mismatches = 0;
  int idle_pct = 22;
  int quiet_cycles = 0;

  initial begin
    for (int i = 0; i < NCH; i++) begin
      slot_valid[i] = 1'b0;
      slot_done[i] = 1'b0;
      slot_limit[i] = '0;
      slot_last[i] = '0;
    end
  end

  function automatic wd_status_t step_watchdog(input wd_cmd_t c);
    wd_status_t st;
    logic hit;
    logic [31:0] elapsed;
    logic ch_ok;
    hit = 1'b0;
    ch_ok = (int'(c.ch) < NCH);
    case (c.func)
      F_START: begin
        if (!running) begin
          start_ms = now_ms;
          expired = 1'b0;
          trip_cause = CAUSE_NONE;
          trip_ch = '0;
          running = 1'b1;
        end
      end
      F_REGISTER: begin
        if (ch_ok) begin
          slot_valid[c.ch] = 1'b1;
          slot_done[c.ch] = 1'b0;
          slot_limit[c.ch] = c.tmo;
          slot_last[c.ch] = now_ms;
        end
      end
      F_PROGRESS: begin
        if (ch_ok && slot_valid[c.ch] && !slot_done[c.ch]) slot_last[c.ch] = now_ms;
      end
      F_COMPLETE: begin
        if (ch_ok && slot_valid[c.ch]) slot_done[c.ch] = 1'b1;
      end
      F_TICK: begin
        now_ms = now_ms + 32'd1;
      end
      F_CHECK: begin
        if (running && !expired) begin
          elapsed = now_ms - start_ms;
          if (elapsed >= deadline_ms) begin
            expired = 1'b1;
            trip_cause = CAUSE_GLOBAL;
            trip_ch = '0;
          end else begin
            for (int i = 0; i < NCH; i++) begin
              elapsed = now_ms - slot_last[i];
              if (!hit && slot_valid[i] && !slot_done[i] && elapsed >= slot_limit[i]) begin
                hit = 1'b1;
                expired = 1'b1;
                trip_cause = CAUSE_CHAN;
                trip_ch = CH_PORT_W'(i);
              end
            end
          end
        end
      end
      F_STOP: begin
        running = 1'b0;
      end
      default: begin
      end
    endcase
    st.timed_out = expired;
    st.cause = trip_cause;
    st.fault_ch = (trip_cause == CAUSE_CHAN) ? trip_ch : '0;
    st.active = running && !expired;
    return st;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("mismatch: %s", msg);
  endtask

  // driver: hold the item until taken, then advance
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        status_due.push_back(step_watchdog(cur_cmd));
        items_taken++;
      end
      if (!start || !busy) begin
        if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
          cur_cmd = pending_cmds.pop_front();
          start <= 1'b1;
          in_func <= cur_cmd.func;
          in_channel <= cur_cmd.ch;
          in_channel_timeout <= cur_cmd.tmo;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      cfg_valid <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      deadline_ms = cfg_data;
      cfg_writes++;
      cfg_valid <= 1'b0;
    end else if (!cfg_valid && deadline_req.size() > 0) begin
      cfg_data <= deadline_req.pop_front();
      cfg_valid <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      got_st = {out_timed_out, out_cause, out_fault_channel, out_active};
      if (status_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result %b/%0d/%0d/%b", out_timed_out,
                                  out_cause, out_fault_channel, out_active));
      end else begin
        want_st = status_due.pop_front();
        if (got_st !== want_st)
          report_mismatch($sformatf("got %b/%0d/%0d/%b want %b/%0d/%0d/%b",
                                    got_st.timed_out, got_st.cause, got_st.fault_ch,
                                    got_st.active, want_st.timed_out, want_st.cause,
                                    want_st.fault_ch, want_st.active));
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[multi_channel_progress_watchdog] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic void push_cmd(input logic [FUNC_W-1:0] f, input logic [CH_PORT_W-1:0] ch,
                                   input logic [LIM_W-1:0] tmo);
    wd_cmd_t c;
    c.func = f;
    c.ch = ch;
    c.tmo = tmo;
    pending_cmds.push_back(c);
    items_pushed++;
  endfunction

  function automatic logic [LIM_W-1:0] pick_limit();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return LIM_W'($urandom_range(0, 30));
    if (r < 80) return '0;
    if (r < 90) return '1;
    return $urandom();
  endfunction

  task automatic settle();
    while (items_taken != items_pushed || status_due.size() != 0 || busy !== 1'b0)
      @(negedge clk);
  endtask

  task automatic load_deadline(input logic [31:0] v);
    int n;
    n = cfg_writes;
    deadline_req.push_back(v);
    while (cfg_writes == n) @(negedge clk);
  endtask

  task automatic run_session();
    logic [CH_PORT_W-1:0] live[$];
    logic [CH_PORT_W-1:0] ch;
    int r;
    if ($urandom_range(0, 99) < 70) push_cmd(F_STOP, CH_PORT_W'($urandom()), $urandom());
    push_cmd(F_START, CH_PORT_W'($urandom()), $urandom());
    repeat ($urandom_range(1, 4)) begin
      ch = CH_PORT_W'($urandom_range(0, NCH - 1));
      live.push_back(ch);
      push_cmd(F_REGISTER, ch, pick_limit());
    end
    repeat ($urandom_range(10, 40)) begin
      r = $urandom_range(0, 99);
      ch = ($urandom_range(0, 99) < 85) ? live[$urandom_range(0, live.size() - 1)]
                                         : CH_PORT_W'($urandom_range(0, NCH - 1));
      if (r < 35) push_cmd(F_TICK, CH_PORT_W'($urandom()), $urandom());
      else if (r < 58) push_cmd(F_CHECK, CH_PORT_W'($urandom()), $urandom());
      else if (r < 78) push_cmd(F_PROGRESS, ch, $urandom());
      else if (r < 84) push_cmd(F_COMPLETE, ch, $urandom());
      else if (r < 89) begin
        ch = CH_PORT_W'($urandom_range(0, NCH - 1));
        live.push_back(ch);
        push_cmd(F_REGISTER, ch, pick_limit());
      end
      else if (r < 92) push_cmd(F_START, CH_PORT_W'($urandom()), $urandom());
      else if (r < 94) push_cmd(F_STOP, CH_PORT_W'($urandom()), $urandom());
      else push_cmd(FUNC_W'($urandom_range(0, 7)), CH_PORT_W'($urandom()), $urandom());
    end
    push_cmd(F_CHECK, CH_PORT_W'($urandom()), $urandom());
  endtask

  initial begin
    logic [31:0] phase_deadline [6];
    int quiet_phase;
    int goal;
    phase_deadline[0] = 32'hFFFF_FFFF;
    phase_deadline[1] = 32'd20;
    phase_deadline[2] = 32'd0;
    phase_deadline[3] = $urandom();
    phase_deadline[4] = 32'd45;
    phase_deadline[5] = 32'd8;
    quiet_phase = $urandom_range(0, 5);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    load_deadline(32'hFFFF_FFFF);
    push_cmd(F_CHECK, 4'd0, 32'd0);
    push_cmd(F_RESERVED, 4'd15, 32'hFFFF_FFFF);
    push_cmd(F_PROGRESS, 4'd3, 32'd0);
    push_cmd(F_COMPLETE, 4'd4, 32'd0);
    push_cmd(F_STOP, 4'd0, 32'd0);
    push_cmd(F_START, 4'd0, 32'd0);
    push_cmd(F_START, 4'd15, 32'hFFFF_FFFF);
    push_cmd(F_REGISTER, 4'd0, 32'hFFFF_FFFF);
    push_cmd(F_REGISTER, 4'd15, 32'd2);
    push_cmd(F_REGISTER, 4'd7, 32'd0);
    push_cmd(F_COMPLETE, 4'd7, 32'd0);
    push_cmd(F_PROGRESS, 4'd7, 32'd0);
    push_cmd(F_CHECK, 4'd0, 32'd0);
    push_cmd(F_TICK, 4'd0, 32'd0);
    push_cmd(F_PROGRESS, 4'd15, 32'd0);
    push_cmd(F_TICK, 4'd0, 32'd0);
    push_cmd(F_TICK, 4'd0, 32'd0);
    push_cmd(F_CHECK, 4'd0, 32'd0);
    push_cmd(F_CHECK, 4'd0, 32'd0);
    push_cmd(F_STOP, 4'd0, 32'd0);
    push_cmd(F_START, 4'd0, 32'd0);
    push_cmd(F_REGISTER, 4'd7, 32'd1);
    push_cmd(F_TICK, 4'd0, 32'd0);
    push_cmd(F_CHECK, 4'd0, 32'd0);
    settle();
    load_deadline(32'd0);
    push_cmd(F_STOP, 4'd0, 32'd0);
    push_cmd(F_START, 4'd0, 32'd0);
    push_cmd(F_CHECK, 4'd0, 32'd0);

    for (int p = 0; p < 6; p++) begin
      settle();
      load_deadline(phase_deadline[p]);
      idle_pct = (p == quiet_phase) ? 0 : 22;
      goal = items_pushed + PHASE_ITEMS;
      while (items_pushed < goal) begin
        if ($urandom_range(0, 99) < 12)
          push_cmd(FUNC_W'($urandom_range(0, 7)), CH_PORT_W'($urandom()), $urandom());
        else run_session();
        @(negedge clk);
      end
    end

    settle();
    repeat (NCH + 4) @(posedge clk);
    if (mismatches == 0 && status_due.size() == 0) begin
      $display("[multi_channel_progress_watchdog] OK");
    end else begin
      $display("[multi_channel_progress_watchdog] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
